### src/rdcc_pkg.sv
`timescale 1ns / 1ps

package rdcc_pkg;

   // widths fixed by the request and result fields
   localparam int KIND_W    = 2;
   localparam int OPERAND_W = 60;
   localparam int RESULT_W  = 60;

   // longest coded number, in decimal digits
   localparam int DIGITS    = 18;
   localparam int DIGIT_W   = 4;
   localparam int BCD_W     = DIGIT_W * DIGITS;
   localparam int OCT_BITS  = 3 * DIGITS;

   // one double-dabble cell per operand bit, one accumulate cell per digit
   localparam int DABBLE_CELLS = OPERAND_W;
   localparam int HORNER_CELLS = DIGITS;

   localparam logic [KIND_W-1:0] KIND_OCT_DEC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OCT_ENC = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BIN_DEC = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BIN_ENC = 2'd3;

   function automatic logic [OPERAND_W-1:0] dec_limit();
      longint unsigned p;
      p = 64'd1;
      for (int i = 0; i < DIGITS; i++) begin
         p = p * 64'd10;
      end
      return OPERAND_W'(p);
   endfunction

   localparam logic [OPERAND_W-1:0] DEC_LIMIT = dec_limit();

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [OPERAND_W-1:0] operand;
   } rdcc_req_type;

   typedef struct packed {
      logic [RESULT_W-1:0] result;
      logic                overflow;
   } rdcc_rsp_type;

   // state carried along the double-dabble chain
   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic                 ovf;
      logic [OPERAND_W-1:0] shreg;
      logic [BCD_W-1:0]     bcd;
   } rdcc_dab_type;

   // state carried along the accumulate chain
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic                ovf;
      logic [BCD_W-1:0]    digits;
      logic [RESULT_W-1:0] acc;
   } rdcc_hor_type;

endpackage

### src/rdcc_dabble_cell.sv
`timescale 1ns / 1ps

module rdcc_dabble_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  vld_in,
   input  rdcc_pkg::rdcc_dab_type dat_in,
   output logic                  vld_out,
   output rdcc_pkg::rdcc_dab_type dat_out
);
   import rdcc_pkg::*;

   logic         vld_ff;
   rdcc_dab_type dat_ff;
   rdcc_dab_type stage_in;
   logic [BCD_W-1:0] adj;

   always_comb begin
      adj = dat_in.bcd;
      for (int j = 0; j < DIGITS; j++) begin
         if (adj[j*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adj[j*DIGIT_W +: DIGIT_W] = adj[j*DIGIT_W +: DIGIT_W] + 4'd3;
         end
      end
      stage_in.kind  = dat_in.kind;
      stage_in.ovf   = dat_in.ovf;
      stage_in.bcd   = {adj[BCD_W-2:0], dat_in.shreg[OPERAND_W-1]};
      // rotate, so the operand is whole again at the end of the chain
      stage_in.shreg = {dat_in.shreg[OPERAND_W-2:0], dat_in.shreg[OPERAND_W-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dat_ff <= stage_in;
      end
   end

   assign vld_out = vld_ff;
   assign dat_out = dat_ff;

endmodule

### src/rdcc_horner_cell.sv
`timescale 1ns / 1ps

module rdcc_horner_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  vld_in,
   input  rdcc_pkg::rdcc_hor_type dat_in,
   output logic                  vld_out,
   output rdcc_pkg::rdcc_hor_type dat_out
);
   import rdcc_pkg::*;

   logic         vld_ff;
   rdcc_hor_type dat_ff;
   rdcc_hor_type stage_in;
   logic [RESULT_W-1:0] digit;

   always_comb begin
      digit = RESULT_W'(dat_in.digits[BCD_W-1 -: DIGIT_W]);
      stage_in        = dat_in;
      stage_in.digits = dat_in.digits << DIGIT_W;
      // acc = acc * radix + digit, radix taken from the request kind
      case (dat_in.kind)
         KIND_OCT_DEC: stage_in.acc = (dat_in.acc << 3) + digit;
         KIND_BIN_DEC: stage_in.acc = (dat_in.acc << 1) + digit;
         default:      stage_in.acc = (dat_in.acc << 3) + (dat_in.acc << 1) + digit;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dat_ff <= stage_in;
      end
   end

   assign vld_out = vld_ff;
   assign dat_out = dat_ff;

endmodule

### src/radix_digit_code_converter.sv
`timescale 1ns / 1ps
// A request is registered in every double-dabble cell, then every accumulate cell.
// Throughput: one request per cycle; the whole cell chain advances together and
// holds only while a result sits unaccepted at the output. A decode request first
// passes a bit-per-cell binary-to-BCD chain, then a per-digit multiply-accumulate
// chain; encode requests take digits from the operand. Synchronous active-high reset
// clears all stage valids; the block takes requests in the cycle after reset.
module radix_digit_code_converter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rdcc_pkg::rdcc_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rdcc_pkg::rdcc_rsp_type rsp_payload
);
   import rdcc_pkg::*;

   logic         en;
   logic         dab_vld [DABBLE_CELLS+1];
   rdcc_dab_type dab_dat [DABBLE_CELLS+1];
   logic         hor_vld [HORNER_CELLS+1];
   rdcc_hor_type hor_dat [HORNER_CELLS+1];
   logic         entry_ovf;
   logic         bcd_ok;
   rdcc_dab_type dab_last;

   assign en        = rsp_ready | ~rsp_valid;
   // refuse requests while reset clears the stage valids
   assign req_ready = en & ~reset;

   always_comb begin
      unique case (req_payload.kind)
         KIND_OCT_ENC: entry_ovf = (req_payload.operand >> OCT_BITS) != '0;
         KIND_BIN_ENC: entry_ovf = (req_payload.operand >> DIGITS) != '0;
         default:      entry_ovf = req_payload.operand >= DEC_LIMIT;
      endcase
   end

   assign dab_vld[0]       = req_valid;
   assign dab_dat[0].kind  = req_payload.kind;
   assign dab_dat[0].ovf   = entry_ovf;
   assign dab_dat[0].shreg = req_payload.operand;
   assign dab_dat[0].bcd   = '0;

   for (genvar i = 0; i < DABBLE_CELLS; i++) begin : g_dab
      rdcc_dabble_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .vld_in  (dab_vld[i]),
         .dat_in  (dab_dat[i]),
         .vld_out (dab_vld[i+1]),
         .dat_out (dab_dat[i+1])
      );
   end

   assign dab_last = dab_dat[DABBLE_CELLS];

   // pick the digit string, most significant digit at the top
   always_comb begin
      hor_dat[0].kind = dab_last.kind;
      hor_dat[0].ovf  = dab_last.ovf;
      hor_dat[0].acc  = '0;
      for (int j = 0; j < DIGITS; j++) begin
         case (dab_last.kind)
            KIND_OCT_ENC:
               hor_dat[0].digits[j*DIGIT_W +: DIGIT_W] = {1'b0, dab_last.shreg[3*j +: 3]};
            KIND_BIN_ENC:
               hor_dat[0].digits[j*DIGIT_W +: DIGIT_W] = {3'b000, dab_last.shreg[j]};
            default:
               hor_dat[0].digits[j*DIGIT_W +: DIGIT_W] = dab_last.bcd[j*DIGIT_W +: DIGIT_W];
         endcase
      end
   end
   assign hor_vld[0] = dab_vld[DABBLE_CELLS];

   for (genvar i = 0; i < HORNER_CELLS; i++) begin : g_hor
      rdcc_horner_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .vld_in  (hor_vld[i]),
         .dat_in  (hor_dat[i]),
         .vld_out (hor_vld[i+1]),
         .dat_out (hor_dat[i+1])
      );
   end

   assign rsp_valid            = hor_vld[HORNER_CELLS];
   assign rsp_payload.overflow = hor_dat[HORNER_CELLS].ovf;
   assign rsp_payload.result   = hor_dat[HORNER_CELLS].ovf ? '0 : hor_dat[HORNER_CELLS].acc;

   // every BCD digit of an in-range decode request ends up at nine or below
   always_comb begin
      bcd_ok = 1'b1;
      for (int j = 0; j < DIGITS; j++) begin
         if (dab_last.bcd[j*DIGIT_W +: DIGIT_W] > 4'd9) begin
            bcd_ok = 1'b0;
         end
      end
   end

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> dab_vld[1])
      else $error("accepted request missing from first cell");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dab_vld[DABBLE_CELLS]) && $stable(hor_vld[1])
                && $stable(rsp_payload))
      else $error("cell chain moved during stall");

   a_bcd_digits: assert property (@(posedge clock) disable iff (reset)
      dab_vld[DABBLE_CELLS] && !dab_last.ovf && !dab_last.kind[0] |-> bcd_ok)
      else $error("binary-to-BCD chain produced an invalid digit");

   a_rsp_from_chain: assert property (@(posedge clock) disable iff (reset)
      en && !hor_vld[HORNER_CELLS-1] |=> !rsp_valid)
      else $error("result appeared without an item in the last cell");

endmodule
